### src/uuid_v7_monotonic_generator_top_defines.svh
// ----------------------------------------------------------------------------
// uuid_v7_monotonic_generator_top_defines
// Assertion macros shared by the uuid v7 generator rtl.
// ----------------------------------------------------------------------------
// every check is sampled on clk and held off while rst is high
`ifndef UUID_V7_MONOTONIC_GENERATOR_TOP_DEFINES_SVH
`define UUID_V7_MONOTONIC_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define UVG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UVG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/uvg_pkg.sv
// ----------------------------------------------------------------------------
// uvg_pkg
// Shared widths, constants and types of the uuid v7 generator.
// ----------------------------------------------------------------------------
`default_nettype none

package uvg_pkg;

  localparam int SECONDS_W = 38;
  localparam int NANOS_W   = 30;
  localparam int UUID_W    = 64;
  localparam int TIME_W    = 64;
  localparam int MS_W      = 48;
  localparam int FRAC_W    = 12;
  localparam int STAMP_W   = MS_W + FRAC_W;
  localparam int MSQ_W     = 11;  // millisecond part of nanoseconds, at most 1073
  localparam int REM_W     = 20;  // remainder below one million
  localparam int RECIP_W   = 31;
  localparam int RECIP_SHIFT = 50;

  localparam int UVG_QUEUE_DEPTH = 2;

  localparam logic [TIME_W-1:0]  SEED_VALUE  = 64'h853c49e6748fea9b;
  localparam logic [TIME_W-1:0]  GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [TIME_W-1:0]  MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [TIME_W-1:0]  MIX_MUL_B   = 64'h94d049bb133111eb;
  localparam logic [REM_W-1:0]   NS_PER_MS   = 20'd1000000;
  // floor(2^50 / 1e6), estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP_MS    = 31'd1125899906;
  localparam logic [3:0]         UUID_VERSION = 4'h7;
  localparam logic [1:0]         UUID_VARIANT = 2'b10;

  typedef logic [STAMP_W-1:0] stamp_t;

  typedef struct packed {
    logic   valid;
    stamp_t stamp;
  } stamp_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

### src/uvg_if.sv
// ----------------------------------------------------------------------------
// uvg_req_if / uvg_rsp_if
// Valid/ready channels of the uuid v7 generator.
// ----------------------------------------------------------------------------
`default_nettype none

interface uvg_req_if import uvg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SECONDS_W-1:0] seconds;
  logic [NANOS_W-1:0]   nanoseconds;

  modport source (output valid, output seconds, output nanoseconds, input ready);
  modport sink   (input valid, input seconds, input nanoseconds, output ready);
endinterface

interface uvg_rsp_if import uvg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [UUID_W-1:0] uuid_high;
  logic [UUID_W-1:0] uuid_low;

  modport source (output valid, output uuid_high, output uuid_low, input ready);
  modport sink   (input valid, input uuid_high, input uuid_low, output ready);
endinterface

`default_nettype wire

### src/uvg_front.sv
// ----------------------------------------------------------------------------
// uvg_front
// Takes a time request and builds the 60-bit timestamp over five steps.
// ----------------------------------------------------------------------------
`default_nettype none

module uvg_front import uvg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  uvg_req_if.sink    req,
  input  wire queue_stat_t stat,
  output stamp_push_t push
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DIV1 = 3'd1;
  localparam logic [2:0] F_REM1 = 3'd2;
  localparam logic [2:0] F_DIV2 = 3'd3;
  localparam logic [2:0] F_FIX2 = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0]           state;
  logic [SECONDS_W-1:0] secs;
  logic [NANOS_W-1:0]   nanos;
  logic [MSQ_W-1:0]     msq;
  logic [REM_W-1:0]     rem;
  logic [FRAC_W-1:0]    frac;
  logic [MS_W-1:0]      ms;

  logic [NANOS_W+RECIP_W-1:0] prod1;
  logic [NANOS_W-1:0]         rem1;
  logic [31:0]                scaled;
  logic [31+RECIP_W:0]        prod2;
  logic [31:0]                rem2;
  logic [MS_W-1:0]            secs_ext;
  logic [MS_W-1:0]            ms_next;

  assign req.ready = (state == F_IDLE);

  assign prod1    = (NANOS_W+RECIP_W)'(nanos) * (NANOS_W+RECIP_W)'(RECIP_MS);
  assign rem1     = nanos - NANOS_W'(msq) * NANOS_W'(NS_PER_MS);
  assign scaled   = {rem, {FRAC_W{1'b0}}};
  assign prod2    = (32+RECIP_W)'(scaled) * (32+RECIP_W)'(RECIP_MS);
  assign rem2     = scaled - 32'(frac) * 32'(NS_PER_MS);
  // times 1000 as 1024 - 32 + 8
  assign secs_ext = MS_W'(secs);
  assign ms_next  = (secs_ext << 10) - (secs_ext << 5) + (secs_ext << 3) + MS_W'(msq);

  assign push.valid = (state == F_PUSH) && !stat.full;
  assign push.stamp = {ms, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req.valid) begin
            secs  <= req.seconds;
            nanos <= req.nanoseconds;
            state <= F_DIV1;
          end
        end
        F_DIV1: begin
          msq   <= prod1[RECIP_SHIFT +: MSQ_W];
          state <= F_REM1;
        end
        F_REM1: begin
          // reciprocal estimate may be one short
          if (rem1 >= NANOS_W'(NS_PER_MS)) begin
            msq <= msq + 1'b1;
            rem <= REM_W'(rem1 - NANOS_W'(NS_PER_MS));
          end else begin
            rem <= REM_W'(rem1);
          end
          state <= F_DIV2;
        end
        F_DIV2: begin
          frac  <= prod2[RECIP_SHIFT +: FRAC_W];
          state <= F_FIX2;
        end
        F_FIX2: begin
          if (rem2 >= 32'(NS_PER_MS)) begin
            frac <= frac + 1'b1;
          end
          ms    <= ms_next;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!stat.full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/uvg_queue.sv
// ----------------------------------------------------------------------------
// uvg_queue
// Short first-in first-out queue of timestamps between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uuid_v7_monotonic_generator_top_defines.svh"

module uvg_queue import uvg_pkg::*; #(
  parameter int DEPTH = UVG_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire stamp_push_t push,
  input  wire logic  pop,
  output stamp_t     head,
  output queue_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  stamp_t        entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      // push and pop together leave the count unchanged
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

  `UVG_ASSERT_IMP(a_no_push_full, push.valid, !stat.full, "push into full queue")
  `UVG_ASSERT_IMP(a_no_pop_empty, pop, !stat.empty, "pop from empty queue")
  `UVG_ASSERT_NXT(a_count_up, push.valid && !pop, count == $past(count) + 1'b1, "count stuck")

endmodule

`default_nettype wire

### src/uvg_back.sv
// ----------------------------------------------------------------------------
// uvg_back
// Monotonic timestamp update, splitmix64 draw and uuid assembly.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uuid_v7_monotonic_generator_top_defines.svh"

module uvg_back import uvg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire stamp_t head,
  input  wire queue_stat_t stat,
  output logic       pop,
  uvg_rsp_if.source  rsp
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL1 = 2'd1;
  localparam logic [1:0] B_MUL2 = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_HL = 2'd1;
  localparam logic [1:0] STEP_LH = 2'd2;

  logic [1:0]        state;
  logic [1:0]        step;
  logic [TIME_W-1:0] last_issued;
  logic [TIME_W-1:0] random_state;
  logic [TIME_W-1:0] z;
  logic [TIME_W-1:0] acc;
  logic [UUID_W-1:0] hi_hold;
  logic              out_valid;
  logic [UUID_W-1:0] out_high;
  logic [UUID_W-1:0] out_low;

  logic [TIME_W-1:0] stamp_ext;
  logic [TIME_W-1:0] issued;
  logic [TIME_W-1:0] random_state_next;
  logic [TIME_W-1:0] mul_const;
  logic [31:0]       a_part;
  logic [31:0]       b_part;
  logic [63:0]       prod;
  logic [TIME_W-1:0] acc_sum;
  logic              load;
  logic              marks_ok;
  logic              stalled;

  assign pop       = (state == B_IDLE) && !stat.empty;
  assign load      = (state == B_DONE) && (!out_valid || rsp.ready);
  assign stamp_ext = TIME_W'(head);
  assign issued    = (stamp_ext > last_issued) ? stamp_ext : last_issued + 1'b1;
  assign random_state_next = random_state + GOLDEN_STEP;

  // one shared 32x32 multiplier, low 64 bits of a 64x64 product in three steps
  assign mul_const = (state == B_MUL1) ? MIX_MUL_A : MIX_MUL_B;
  assign a_part    = (step == STEP_HL) ? z[63:32] : z[31:0];
  assign b_part    = (step == STEP_LH) ? mul_const[63:32] : mul_const[31:0];
  assign prod      = 64'(a_part) * 64'(b_part);
  assign acc_sum   = (step == STEP_LL) ? prod : acc + {prod[31:0], 32'b0};

  assign rsp.valid     = out_valid;
  assign rsp.uuid_high = out_high;
  assign rsp.uuid_low  = out_low;

  assign marks_ok = (rsp.uuid_high[15:12] == UUID_VERSION) &&
                    (rsp.uuid_low[63:62] == UUID_VARIANT);
  assign stalled  = (state == B_DONE) && out_valid && !rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      step         <= STEP_LL;
      last_issued  <= '0;
      random_state <= SEED_VALUE;
      out_valid    <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            last_issued  <= issued;
            hi_hold      <= {issued[FRAC_W +: MS_W], UUID_VERSION, issued[FRAC_W-1:0]};
            random_state <= random_state_next;
            z            <= random_state_next ^ (random_state_next >> 30);
            step         <= STEP_LL;
            state        <= B_MUL1;
          end
        end
        B_MUL1, B_MUL2: begin
          if (step == STEP_LH) begin
            step <= STEP_LL;
            if (state == B_MUL1) begin
              z     <= acc_sum ^ (acc_sum >> 27);
              state <= B_MUL2;
            end else begin
              z     <= acc_sum ^ (acc_sum >> 31);
              state <= B_DONE;
            end
          end else begin
            acc  <= acc_sum;
            step <= step + 1'b1;
          end
        end
        B_DONE: begin
          if (load) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase

      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_high <= hi_hold;
      out_low  <= {UUID_VARIANT, z[UUID_W-3:0]};
    end
  end

  `UVG_ASSERT_NXT(a_time_moves, pop, last_issued != $past(last_issued), "issued time repeated")
  `UVG_ASSERT_IMP(a_uuid_marks, rsp.valid, marks_ok, "version or variant bits wrong")
  `UVG_ASSERT_NXT(a_done_waits, stalled, state == B_DONE, "result dropped under stall")

endmodule

`default_nettype wire

### src/uuid_v7_monotonic_generator_top.sv
// ----------------------------------------------------------------------------
// uuid_v7_monotonic_generator_top
// UUID version 7 generator with a monotonic timestamp and splitmix64 bits.
// ----------------------------------------------------------------------------
// usage:
//   req carries seconds and nanoseconds of real time; one transaction in
//   gives one transaction out on rsp with uuid_high and uuid_low.
//   the front converts the time to a 60-bit timestamp (two reciprocal
//   multiplies, each with a one-step correction) and pushes it into a
//   short queue; req.ready is high only while the front is idle.
//   the back pops a timestamp, makes it strictly larger than the last one
//   issued, advances the random state and runs the two mixing multiplies
//   on one shared 32x32 multiplier, three partial products each.
//   the back takes one timestamp at a time: pop, its six multiplier
//   steps and the output load all finish before it pops the next.
//   rsp is held in an output register; while rsp.ready is low the back
//   keeps its finished result, the queue fills, and then req.ready drops.
//   reset (rst, synchronous) empties the queue, clears the last issued
//   time and loads the random seed; no result is pending afterward.
// ----------------------------------------------------------------------------
`default_nettype none

module uuid_v7_monotonic_generator_top import uvg_pkg::*; #(
  parameter int QUEUE_DEPTH = UVG_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  uvg_req_if.sink   req,
  uvg_rsp_if.source rsp
);

  stamp_push_t push;
  queue_stat_t stat;
  stamp_t      head;
  logic        pop;

  uvg_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat),
    .push (push)
  );

  uvg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  uvg_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .stat (stat),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire
